### rtl/tis_pkg.sv
// Shared types and constants for the trie insert/search block.
`default_nettype none
package tis_pkg;

  localparam int NODE_COUNT   = 1024;
  localparam int ALPHABET     = 26;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int FREE_W       = NODE_W + 1;
  localparam int LETTER_W     = 5;
  localparam int SLOT_COUNT   = NODE_COUNT * ALPHABET;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int LEN_W        = 16;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int OUT_W        = 40;

  localparam logic [7:0]       FIRST_LETTER = 8'd97;
  localparam logic [LEN_W-1:0] LEN_MAX      = {LEN_W{1'b1}};

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // One classified character word as queued between front and back.
  typedef struct packed {
    logic                command;
    logic                has_char;
    logic                last;
    logic                bad;
    logic [LETTER_W-1:0] letter;
  } item_t;

endpackage
`default_nettype wire

### rtl/tis_front.sv
// Front end: accepts input words, classifies the character, feeds the queue.
`default_nettype none
module tis_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,
  input  wire logic [1:0]   s_tuser,
  input  wire logic         s_tlast,
  output logic              push_valid,
  input  wire logic         push_ready,
  output tis_pkg::item_t    push_item
);

  logic           vld;
  tis_pkg::item_t item;
  tis_pkg::item_t item_next;
  logic [7:0]     offs;

  always_comb begin
    offs = s_tdata - tis_pkg::FIRST_LETTER;
    item_next.command  = s_tuser[0];
    item_next.has_char = s_tuser[1];
    item_next.last     = s_tlast;
    item_next.bad      = (s_tdata < tis_pkg::FIRST_LETTER) ||
                         (offs >= 8'(tis_pkg::ALPHABET));
    item_next.letter   = offs[tis_pkg::LETTER_W-1:0];
  end

  assign s_tready   = !vld || push_ready;
  assign push_valid = vld;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

### rtl/tis_fifo.sv
// Short queue of classified words between front and back.
`default_nettype none
module tis_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire tis_pkg::item_t push_item,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output tis_pkg::item_t     pop_item
);

  tis_pkg::item_t                  mem [tis_pkg::FIFO_DEPTH];
  logic [tis_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [tis_pkg::FIFO_AW-1:0]     rd_ptr;
  logic [tis_pkg::FIFO_AW:0]       count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = count != (tis_pkg::FIFO_AW+1)'(tis_pkg::FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

### rtl/tis_back.sv
// Back end: walks the trie in the node memories and builds the result word.
`default_nettype none
module tis_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire tis_pkg::item_t pop_item,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [tis_pkg::OUT_W-1:0] m_tdata
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_FIN} state_t;

  logic [tis_pkg::NODE_W-1:0] child_mem [tis_pkg::SLOT_COUNT];
  logic                       leaf_mem  [tis_pkg::NODE_COUNT];

  state_t                       state;
  logic [tis_pkg::SLOT_W-1:0]   clr_addr;
  logic [tis_pkg::FREE_W-1:0]   next_free;
  logic [tis_pkg::NODE_W-1:0]   cur;
  logic                         key_active;
  logic                         key_cmd;
  logic [1:0]                   key_status;
  logic [tis_pkg::LEN_W-1:0]    key_count;
  logic [tis_pkg::LEN_W-1:0]    longest;
  logic                         key_miss;
  logic [tis_pkg::SLOT_W-1:0]   slot;
  logic                         last_pend;
  logic [tis_pkg::NODE_W-1:0]   child_q;
  logic                         leaf_q;
  logic                         out_vld;
  logic [tis_pkg::OUT_W-1:0]    out_data;

  // Effective key context for the word at the queue head.
  logic                         eff_cmd;
  logic [1:0]                   eff_status;
  logic [tis_pkg::LEN_W-1:0]    eff_count;
  logic                         eff_miss;
  logic [tis_pkg::NODE_W-1:0]   eff_cur;
  logic [tis_pkg::LEN_W-1:0]    cnt_new;
  logic                         stopped;
  logic                         go_look;
  logic [1:0]                   status_new;
  logic [tis_pkg::SLOT_W-1:0]   slot_calc;

  logic                         alloc;
  logic                         lk_miss;
  logic                         lk_full;
  logic [tis_pkg::NODE_W-1:0]   child_sel;
  logic [tis_pkg::NODE_W-1:0]   leaf_rd_addr;

  logic                         ok;
  logic                         mark;
  logic                         out_free;
  logic                         fin_go;
  logic [tis_pkg::LEN_W-1:0]    longest_new;

  logic                         cw_en;
  logic [tis_pkg::SLOT_W-1:0]   cw_addr;
  logic [tis_pkg::NODE_W-1:0]   cw_data;
  logic                         lw_en;
  logic [tis_pkg::NODE_W-1:0]   lw_addr;
  logic                         lw_data;

  always_comb begin
    eff_cmd    = key_active ? key_cmd    : pop_item.command;
    eff_status = key_active ? key_status : tis_pkg::ST_OK;
    eff_count  = key_active ? key_count  : '0;
    eff_miss   = key_active ? key_miss   : 1'b0;
    eff_cur    = key_active ? cur        : '0;
    cnt_new    = (pop_item.has_char && eff_count != tis_pkg::LEN_MAX) ?
                 eff_count + 1'b1 : eff_count;
    stopped    = (eff_status != tis_pkg::ST_OK) || eff_miss;
    go_look    = pop_item.has_char && !stopped && !pop_item.bad;
    status_new = (pop_item.has_char && !stopped && pop_item.bad) ?
                 tis_pkg::ST_BAD : eff_status;
    slot_calc  = tis_pkg::SLOT_W'(eff_cur) * tis_pkg::SLOT_W'(tis_pkg::ALPHABET) +
                 tis_pkg::SLOT_W'(pop_item.letter);
  end

  always_comb begin
    lk_miss = 1'b0;
    lk_full = 1'b0;
    alloc   = 1'b0;
    if (child_q == '0) begin
      if (key_cmd == tis_pkg::CMD_SEARCH) begin
        lk_miss = 1'b1;
      end else if (next_free == tis_pkg::FREE_W'(tis_pkg::NODE_COUNT)) begin
        lk_full = 1'b1;
      end else begin
        alloc = 1'b1;
      end
    end
    if (alloc)              child_sel = next_free[tis_pkg::NODE_W-1:0];
    else if (child_q != '0) child_sel = child_q;
    else                    child_sel = cur;
    leaf_rd_addr = (state == S_LOOK) ? child_sel : eff_cur;
  end

  always_comb begin
    ok          = (key_status == tis_pkg::ST_OK) && !key_miss;
    mark        = ok && (key_cmd == tis_pkg::CMD_INSERT);
    out_free    = !out_vld || m_tready;
    fin_go      = (state == S_FIN) && out_free;
    longest_new = (mark && key_count > longest) ? key_count : longest;
  end

  // Memory write ports: clearing pass, child allocation, leaf marking.
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = slot;
    cw_data = next_free[tis_pkg::NODE_W-1:0];
    lw_en   = 1'b0;
    lw_addr = cur;
    lw_data = 1'b1;
    if (state == S_CLEAR) begin
      cw_en   = 1'b1;
      cw_addr = clr_addr;
      cw_data = '0;
      lw_en   = clr_addr < tis_pkg::SLOT_W'(tis_pkg::NODE_COUNT);
      lw_addr = clr_addr[tis_pkg::NODE_W-1:0];
      lw_data = 1'b0;
    end else if (state == S_LOOK) begin
      cw_en = alloc;
    end else if (state == S_FIN) begin
      lw_en = mark && out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) child_mem[cw_addr] <= cw_data;
    if (lw_en) leaf_mem[lw_addr]  <= lw_data;
    child_q <= child_mem[slot_calc];
    leaf_q  <= leaf_mem[leaf_rd_addr];
  end

  assign pop_ready = (state == S_IDLE);
  assign m_tvalid  = out_vld;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      next_free  <= tis_pkg::FREE_W'(1);
      cur        <= '0;
      key_active <= 1'b0;
      key_cmd    <= tis_pkg::CMD_INSERT;
      key_status <= tis_pkg::ST_OK;
      key_count  <= '0;
      longest    <= '0;
      key_miss   <= 1'b0;
      last_pend  <= 1'b0;
      out_vld    <= 1'b0;
    end else begin
      if (out_vld && m_tready && !fin_go) out_vld <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == tis_pkg::SLOT_W'(tis_pkg::SLOT_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop_valid) begin
            key_active <= 1'b1;
            key_cmd    <= eff_cmd;
            key_status <= status_new;
            key_count  <= cnt_new;
            key_miss   <= eff_miss;
            cur        <= eff_cur;
            slot       <= slot_calc;
            last_pend  <= pop_item.last;
            if (go_look)            state <= S_LOOK;
            else if (pop_item.last) state <= S_FIN;
          end
        end
        S_LOOK: begin
          cur <= child_sel;
          if (lk_miss) key_miss   <= 1'b1;
          if (lk_full) key_status <= tis_pkg::ST_FULL;
          if (alloc)   next_free  <= next_free + 1'b1;
          state <= last_pend ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (out_free) begin
            out_vld    <= 1'b1;
            out_data   <= {4'd0, longest_new, key_count, key_status,
                           ok && (mark || leaf_q), ok};
            longest    <= longest_new;
            key_active <= 1'b0;
            cur        <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/trie_insert_search.sv
// Trie insert/search top level: front end, word queue, back end.
//
// Keys arrive one character word at a time on the s_ channel; s_tlast closes a key.
// s_tuser carries the command (insert or search, taken from the first word of a key)
// and a has-character flag; s_tdata holds the raw character byte, a..z valid.
// Each closing word yields one result word on the m_ channel with found, full-key
// flag, status, key length and longest inserted key length.
// Back-end steps: a character word that still walks the trie passes the idle state
// (child memory read) and the look state (decide/allocate); any other word is handled
// in the idle state alone. The closing word adds the finish state for the leaf-mark read.
// Path of a closing word: front-end register, queue, idle state, look state (only when
// it walks the trie), finish state, then the output register that holds the result word.
// The front end and a 4-word queue keep taking words while the back end is busy.
// Reset: the node pool empties; a clearing pass writes all 26624 child slots and the
// leaf marks, one per cycle, during which no word is accepted by the back end.
// When the receiver stalls, the result word holds in the output register and the
// back end waits there; the queue then fills and s_tready drops.
`default_nettype none
module trie_insert_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_byte
  input  wire logic [1:0]  s_tuser,   // command, has_char
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // found, full_key, status[1:0], key_length[15:0],
                                      // longest_key[15:0], zero pad[3:0]
);

  logic           push_valid;
  logic           push_ready;
  tis_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  tis_pkg::item_t pop_item;

  tis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tis_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
